[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// Each macro expects signal clk in the scope where it is used; CLDQ_ASSERT also expects rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, ignored while reset is high.
`define CLDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every rising edge, reset included.
`define CLDQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/cldq_pkg.sv]
// Shared types and constants of the circular list deque search unit.
// No dependencies.
package cldq_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int VALUE_W       = 32;
  localparam int ACTION_W      = 3;
  localparam int STATUS_W      = 2;
  localparam int POS_W         = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_REM_FRONT = 3'd2,
    ACT_REM_BACK  = 3'd3,
    ACT_SEARCH    = 3'd4,
    ACT_TRAVERSE  = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_REMOVE,
    S_SEARCH,
    S_TRAVERSE
  } state_t;

endpackage

[rtl/cldq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Uses cldq_pkg for default sizes only.
module cldq_ram #(
  parameter int WIDTH = cldq_pkg::VALUE_W,
  parameter int DEPTH = cldq_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // hold read data when no read is issued
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/circular_list_deque_search_unit.sv]
// Circular list deque with search: ring of DEPTH values in one RAM (cldq_ram), cldq_pkg.
// One request at a time. Insert writes from the execute state, remove answers from the
// remove state, search reads up to count elements, traverse streams one element per
// cycle from the RAM read port. A stalled output holds the sequencer until taken.
// Reset (synchronous) empties the list; the RAM needs no clearing pass.
module circular_list_deque_search_unit #(
  parameter int DEPTH = cldq_pkg::DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [cldq_pkg::ACTION_W-1:0]        action,
  input  logic signed [cldq_pkg::VALUE_W-1:0]  item_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [cldq_pkg::STATUS_W-1:0]        status,
  output logic signed [cldq_pkg::VALUE_W-1:0]  result_value,
  output logic [cldq_pkg::POS_W-1:0]           position,
  output logic                                 last
);
  import cldq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  state_t              state, state_next;
  logic [IDX_W-1:0]    head, head_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [IDX_W-1:0]    idx, idx_next;
  logic [IDX_W-1:0]    scan_ptr, scan_next;
  logic [ACTION_W-1:0] req_action;
  logic [VALUE_W-1:0]  req_value;
  logic                take_req;

  logic                wr_en, rd_en;
  logic [IDX_W-1:0]    wr_addr, rd_addr;
  logic [VALUE_W-1:0]  rd_data;

  logic                load_out, out_free, idx_last;
  status_t             res_status;
  logic [VALUE_W-1:0]  res_value;
  logic [POS_W-1:0]    res_pos;
  logic                res_last;

  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(DEPTH - 1)) ? '0 : p + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] p);
    return (p == '0) ? IDX_W'(DEPTH - 1) : p - IDX_W'(1);
  endfunction

  cldq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (req_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign idx_last = ((CNT_W'(idx) + CNT_W'(1)) == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    scan_ptr <= scan_next;
    if (take_req) begin
      req_action <= action;
      req_value  <= item_value;
    end
  end

  always_comb begin
    state_next = state;
    head_next  = head;
    count_next = count;
    idx_next   = idx;
    scan_next  = scan_ptr;
    take_req   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = head;
    rd_en      = 1'b0;
    rd_addr    = head;
    load_out   = 1'b0;
    res_status = ST_DONE;
    res_value  = '0;
    res_pos    = '0;
    res_last   = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          take_req   = 1'b1;
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (req_action) inside
          ACT_INS_FRONT, ACT_INS_BACK: begin
            if (out_free) begin
              load_out   = 1'b1;
              state_next = S_IDLE;
              if (count == CNT_W'(DEPTH)) begin
                res_status = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + CNT_W'(1);
                if (req_action == ACT_INS_FRONT) begin
                  head_next = wrap_dec(head);
                  wr_addr   = wrap_dec(head);
                end else begin
                  wr_addr = slot_of(head, count);
                end
              end
            end
          end
          ACT_REM_FRONT, ACT_REM_BACK, ACT_SEARCH, ACT_TRAVERSE: begin
            if (count == '0) begin
              if (out_free) begin
                load_out   = 1'b1;
                res_status = ST_EMPTY;
                state_next = S_IDLE;
              end
            end else begin
              rd_en     = 1'b1;
              idx_next  = '0;
              scan_next = head;
              if (req_action == ACT_REM_BACK) begin
                rd_addr = slot_of(head, count - CNT_W'(1));
              end
              if (req_action == ACT_SEARCH) begin
                state_next = S_SEARCH;
              end else if (req_action == ACT_TRAVERSE) begin
                state_next = S_TRAVERSE;
              end else begin
                state_next = S_REMOVE;
              end
            end
          end
          default: begin
            // unused codes: drop the request
            state_next = S_IDLE;
          end
        endcase
      end

      S_REMOVE: begin
        if (out_free) begin
          load_out   = 1'b1;
          res_value  = rd_data;
          count_next = count - CNT_W'(1);
          state_next = S_IDLE;
          if (req_action == ACT_REM_FRONT) begin
            res_pos   = POS_W'(1);
            head_next = wrap_inc(head);
          end else begin
            res_pos = POS_W'(count);
          end
        end
      end

      S_SEARCH: begin
        if (rd_data == req_value) begin
          if (out_free) begin
            load_out   = 1'b1;
            res_value  = rd_data;
            res_pos    = POS_W'(idx) + POS_W'(1);
            state_next = S_IDLE;
          end
        end else if (idx_last) begin
          if (out_free) begin
            load_out   = 1'b1;
            res_status = ST_NOT_FOUND;
            state_next = S_IDLE;
          end
        end else begin
          // advance to the next element
          rd_en     = 1'b1;
          rd_addr   = wrap_inc(scan_ptr);
          scan_next = wrap_inc(scan_ptr);
          idx_next  = idx + IDX_W'(1);
        end
      end

      S_TRAVERSE: begin
        if (out_free) begin
          load_out  = 1'b1;
          res_value = rd_data;
          res_pos   = POS_W'(idx) + POS_W'(1);
          res_last  = idx_last;
          if (idx_last) begin
            state_next = S_IDLE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = wrap_inc(scan_ptr);
            scan_next = wrap_inc(scan_ptr);
            idx_next  = idx + IDX_W'(1);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status       <= res_status;
      result_value <= res_value;
      position     <= res_pos;
      last         <= res_last;
    end
  end

endmodule

[rtl/cldq_checker.sv]
// Port-level checks for circular_list_deque_search_unit, bound to the top level.
// Depends on cldq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cldq_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [cldq_pkg::STATUS_W-1:0]       status,
  input logic signed [cldq_pkg::VALUE_W-1:0] result_value,
  input logic [cldq_pkg::POS_W-1:0]          position,
  input logic                                last
);
  import cldq_pkg::*;

  // reset leaves the unit idle with no pending result
  `CLDQ_ASSERT_RST(a_reset_idle, rst |=> !in_stall && !out_valid, "not idle after reset")

  `CLDQ_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(status) && $stable(result_value) && $stable(position) && $stable(last), "stalled result changed")

  // any error status is a single, final result with no element
  `CLDQ_ASSERT(a_err_empty, out_valid && (status != ST_DONE) |-> last && (position == '0) && (result_value == '0), "error result carries data")

  // a traverse streams with no gaps and rising positions
  `CLDQ_ASSERT(a_trav_stream, out_valid && !out_stall && !last |=> out_valid && (position == $past(position) + 7'd1), "traverse stream broken")

endmodule

bind circular_list_deque_search_unit cldq_checker u_cldq_checker (.*);

[tb/circular_list_deque_search_unit_tb.sv]
// Self-checking testbench for circular_list_deque_search_unit: directed and random requests,
// each result compared against an in-bench list predictor. Depends on cldq_pkg and the
// RTL of the unit; needs nothing else.
`timescale 1ns / 100ps

module circular_list_deque_search_unit_tb;
  import cldq_pkg::*;

  localparam int LIST_DEPTH       = DEPTH_DEFAULT;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int TAIL_CYCLES      = LIST_DEPTH + 16;

  // action codes the unit must ignore
  localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    status_t                    st;
    logic signed [VALUE_W-1:0]  value;
    logic [POS_W-1:0]           pos;
    logic                       is_last;
  } list_result_t;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  logic [ACTION_W-1:0]         action;
  logic signed [VALUE_W-1:0]   item_value;
  logic                        out_valid;
  logic                        out_stall;
  logic [STATUS_W-1:0]         status;
  logic signed [VALUE_W-1:0]   result_value;
  logic [POS_W-1:0]            position;
  logic                        last;

  // predicted list contents
  logic signed [VALUE_W-1:0]   ring_mem [LIST_DEPTH];
  logic [5:0]                  ring_head = '0;
  int                          ring_count = 0;

  list_result_t                pending_results [$];

  bit src_idle_on     = 1'b1;
  bit sink_idle_on    = 1'b1;
  bit hold_output_req = 1'b0;
  bit hold_active     = 1'b0;

  int fail_count      = 0;
  int requests_sent   = 0;
  int ignored_sent    = 0;
  int results_checked = 0;
  int peak_count      = 0;
  int idle_cycles     = 0;

  circular_list_deque_search_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .item_value   (item_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .result_value (result_value),
    .position     (position),
    .last         (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int slot_at(int offset);
    return (int'(ring_head) + offset) % LIST_DEPTH;
  endfunction

  // Update the predicted list for one accepted request and queue its results.
  function automatic void apply_request(logic [ACTION_W-1:0] code,
                                        logic signed [VALUE_W-1:0] v);
    list_result_t r;
    r = '{st: ST_DONE, value: '0, pos: '0, is_last: 1'b1};
    case (code)
      ACT_INS_FRONT, ACT_INS_BACK: begin
        if (ring_count >= LIST_DEPTH) begin
          r.st = ST_FULL;
        end else begin
          if (code == ACT_INS_FRONT) begin
            ring_head = (ring_head == '0) ? 6'(LIST_DEPTH - 1) : ring_head - 6'd1;
            ring_mem[ring_head] = v;
          end else begin
            ring_mem[slot_at(ring_count)] = v;
          end
          ring_count++;
          if (ring_count > peak_count) peak_count = ring_count;
        end
      end
      ACT_REM_FRONT, ACT_REM_BACK: begin
        if (ring_count == 0) begin
          r.st = ST_EMPTY;
        end else if (code == ACT_REM_FRONT) begin
          r.value = ring_mem[ring_head];
          r.pos = 7'd1;
          ring_head = 6'(slot_at(1));
          ring_count--;
        end else begin
          r.value = ring_mem[slot_at(ring_count - 1)];
          r.pos = 7'(ring_count);
          ring_count--;
        end
      end
      ACT_SEARCH: begin
        if (ring_count == 0) begin
          r.st = ST_EMPTY;
        end else begin
          r.st = ST_NOT_FOUND;
          for (int i = 0; i < ring_count; i++) begin
            if (ring_mem[slot_at(i)] == v) begin
              r.st = ST_DONE;
              r.value = v;
              r.pos = 7'(i + 1);
              break;
            end
          end
        end
      end
      ACT_TRAVERSE: begin
        if (ring_count == 0) begin
          r.st = ST_EMPTY;
        end else begin
          for (int i = 0; i < ring_count; i++) begin
            r.value = ring_mem[slot_at(i)];
            r.pos = 7'(i + 1);
            r.is_last = (i == ring_count - 1);
            pending_results.push_back(r);
          end
          return;
        end
      end
      default: return;
    endcase
    pending_results.push_back(r);
  endfunction

  function automatic logic signed [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 5))
      0, 1:    return 32'($urandom_range(0, 7)) - 32'sd4;
      2:       return $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
      default: return $urandom();
    endcase
  endfunction

  // Mostly a value already in the list, so that searches hit.
  function automatic logic signed [VALUE_W-1:0] search_value();
    if (ring_count > 0 && $urandom_range(0, 9) < 6)
      return ring_mem[slot_at($urandom_range(0, ring_count - 1))];
    return random_value();
  endfunction

  // Offer one request and hold it until the transfer.
  task automatic send_request(logic [ACTION_W-1:0] code, logic signed [VALUE_W-1:0] v);
    @(negedge clk);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    action     <= code;
    item_value <= v;
    in_valid   <= 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    apply_request(code, v);
    if (code == ACT_SPARE_6 || code == ACT_SPARE_7) ignored_sent++;
    else requests_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_list();
    send_request(ACT_REM_FRONT, random_value());
    send_request(ACT_REM_BACK, random_value());
    send_request(ACT_SEARCH, '0);
    send_request(ACT_TRAVERSE, random_value());
    send_request(ACT_SPARE_6, random_value());
    send_request(ACT_SPARE_7, random_value());
  endtask

  task automatic test_extreme_values();
    // list becomes 0, MIN, MAX, -1, 1 with the head wrapping below slot zero
    send_request(ACT_INS_BACK, VALUE_MAX);
    send_request(ACT_INS_FRONT, VALUE_MIN);
    send_request(ACT_INS_BACK, -32'sd1);
    send_request(ACT_INS_FRONT, '0);
    send_request(ACT_INS_BACK, 32'sd1);
    send_request(ACT_TRAVERSE, '0);
    send_request(ACT_SEARCH, VALUE_MIN);
    send_request(ACT_SEARCH, 32'sh5A5A_5A5A);
    send_request(ACT_REM_FRONT, random_value());
    send_request(ACT_REM_BACK, random_value());
    send_request(ACT_REM_FRONT, random_value());
    send_request(ACT_REM_BACK, random_value());
    // back removal of the only element empties the list
    send_request(ACT_REM_BACK, random_value());
  endtask

  task automatic test_single_element();
    logic signed [VALUE_W-1:0] v;
    v = $urandom();
    send_request(ACT_INS_FRONT, v);
    send_request(ACT_SEARCH, v);
    send_request(ACT_REM_FRONT, '0);
    send_request(ACT_TRAVERSE, '0);
  endtask

  task automatic test_full_store();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    while (ring_count < LIST_DEPTH)
      send_request($urandom_range(0, 1) ? ACT_INS_FRONT : ACT_INS_BACK, random_value());
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    send_request(ACT_INS_BACK, random_value());
    send_request(ACT_INS_FRONT, random_value());
    send_request(ACT_TRAVERSE, '0);
    send_request(ACT_SEARCH, ring_mem[slot_at(LIST_DEPTH - 1)]);
    send_request(ACT_SEARCH, random_value());
    while (ring_count > 0)
      send_request($urandom_range(0, 1) ? ACT_REM_FRONT : ACT_REM_BACK, random_value());
    send_request(ACT_REM_BACK, random_value());
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    repeat (6) send_request(ACT_INS_BACK, random_value());
    // drop the request line while waiting for the hold to start
    wait_drained();
    hold_output_req = 1'b1;
    while (!hold_active) @(posedge clk);
    // keep offering while results are held back
    send_request(ACT_TRAVERSE, '0);
    send_request(ACT_SEARCH, search_value());
    send_request(ACT_REM_FRONT, '0);
    send_request(ACT_INS_FRONT, random_value());
    send_request(ACT_TRAVERSE, '0);
    wait_drained();
  endtask

  task automatic test_random_mix(int n_requests);
    int sent;
    int pick;
    sent = 0;
    while (sent < n_requests) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_request($urandom_range(0, 1) ? ACT_SPARE_7 : ACT_SPARE_6, random_value());
        continue;
      end
      sent++;
      if (pick < 22)      send_request(ACT_INS_FRONT, random_value());
      else if (pick < 42) send_request(ACT_INS_BACK, random_value());
      else if (pick < 54) send_request(ACT_REM_FRONT, random_value());
      else if (pick < 66) send_request(ACT_REM_BACK, random_value());
      else if (pick < 90) send_request(ACT_SEARCH, search_value());
      else                send_request(ACT_TRAVERSE, random_value());
    end
  endtask

  // Receiver: random stall bursts, or one long hold on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output_req) begin
        hold_active = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_active = 1'b0;
        hold_output_req = 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d value %0d position %0d last %0d",
               status, result_value, position, last);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (status !== want.st) begin
          $error("field status: expected %0d, actual %0d", want.st, status);
          fail_count++;
        end
        if (result_value !== want.value) begin
          $error("field result_value: expected %0d, actual %0d", want.value, result_value);
          fail_count++;
        end
        if (position !== want.pos) begin
          $error("field position: expected %0d, actual %0d", want.pos, position);
          fail_count++;
        end
        if (last !== want.is_last) begin
          $error("field last: expected %0d, actual %0d", want.is_last, last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    action     = '0;
    item_value = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_extreme_values();
    test_single_element();
    test_full_store();
    test_output_backpressure();
    test_random_mix(120);
    // quiet tail: no idling on either side
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    test_random_mix(30);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests plus %0d ignored codes, %0d results checked",
             requests_sent, ignored_sent, results_checked);
    $display("list grew to %0d of %0d entries, %0d mismatches",
             peak_count, LIST_DEPTH, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/cldq_pkg.sv
rtl/cldq_ram.sv
rtl/circular_list_deque_search_unit.sv
rtl/cldq_checker.sv
tb/circular_list_deque_search_unit_tb.sv
